// ----- rtl/pdf_pkg.sv -----
// Shared types and constants of the packet duplicate filter.
// Depends on nothing; every other file of the block but pdf_checker refers to it by scoped names.
package pdf_pkg;

	// Default number of table entries.
	localparam int DEF_ENTRIES = 16;

	// Width of one field of the key and of the packed key.
	localparam int FIELD_W = 8;
	localparam int KEY_W   = 3 * FIELD_W;

	// Bit position of the source node inside a packed key.
	localparam int SRC_LSB = FIELD_W;

	// Operation codes of an input item.
	typedef enum logic [1:0] {
		OP_ACCEPT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_PURGE  = 2'd2,
		OP_CLEAR  = 2'd3
	} pdf_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic scan_step;
		logic commit;
		logic result_load;
	} pdf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		pdf_op_t op;
		logic    scan_last;
		logic    out_free;
	} pdf_sts_t;

endpackage

// ----- rtl/pdf_if.sv -----
// Valid/ready channel interfaces of the packet duplicate filter.
// Depends on pdf_pkg for the field widths.
interface pdf_in_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   operation;
	logic [pdf_pkg::FIELD_W-1:0]  packet_type;
	logic [pdf_pkg::FIELD_W-1:0]  source_id;
	logic [pdf_pkg::FIELD_W-1:0]  sequence_req;

	modport source (output valid, operation, packet_type, source_id, sequence_req,
		input ready);
	modport sink (input valid, operation, packet_type, source_id, sequence_req,
		output ready);
endinterface

interface pdf_out_if;
	logic valid;
	logic ready;
	logic present;
	logic accepted;

	modport source (output valid, present, accepted, input ready);
	modport sink (input valid, present, accepted, output ready);
endinterface

// ----- rtl/pdf_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on pdf_pkg only for the default width and depth.
module pdf_ram #(
	parameter int WIDTH = pdf_pkg::KEY_W,
	parameter int DEPTH = pdf_pkg::DEF_ENTRIES
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/pdf_ctrl.sv -----
// Controller of the packet duplicate filter: sequences load, scan, commit and result.
// Depends on pdf_pkg for the command and status structs.
module pdf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pdf_pkg::pdf_sts_t sts,
	output pdf_pkg::pdf_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_RESULT
	} state_t;

	state_t state_q;

	// One item at a time is taken, only while idle.
	assign in_ready = (state_q == ST_IDLE);

	// Commands follow from the state and the datapath status.
	always_comb begin
		cmd             = '0;
		cmd.load_item   = (state_q == ST_IDLE) && in_valid;
		cmd.scan_step   = (state_q == ST_SCAN);
		cmd.commit      = (state_q == ST_COMMIT);
		cmd.result_load = (state_q == ST_RESULT) && sts.out_free;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						// A clear needs no scan of the table.
						state_q <= (sts.op == pdf_pkg::OP_CLEAR) ? ST_COMMIT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/pdf_datapath.sv -----
// Datapath of the packet duplicate filter: item register, key RAM, valid bits,
// scan compare, write pointer and result register.
// Depends on pdf_pkg and pdf_ram.
module pdf_datapath #(
	parameter int ENTRIES = pdf_pkg::DEF_ENTRIES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pdf_pkg::pdf_cmd_t           cmd,
	output pdf_pkg::pdf_sts_t           sts,
	input  logic [1:0]                  operation,
	input  logic [pdf_pkg::FIELD_W-1:0] packet_type,
	input  logic [pdf_pkg::FIELD_W-1:0] source_id,
	input  logic [pdf_pkg::FIELD_W-1:0] sequence_req,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        present,
	output logic                        accepted
);

	localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

	pdf_pkg::pdf_op_t          op_q;
	logic [pdf_pkg::KEY_W-1:0] key_q;
	logic [IDXW-1:0]           idx_q;
	logic [IDXW-1:0]           idx_s1;
	logic                      rd_vld_s1;
	logic                      hit_q;
	logic [ENTRIES-1:0]        valid_q;
	logic [IDXW-1:0]           wslot_q;
	logic                      out_valid_q;
	logic                      present_q;
	logic                      accepted_q;

	logic [pdf_pkg::KEY_W-1:0] rd_data;
	logic                      entry_ok;
	logic                      key_match;
	logic                      src_match;
	logic                      store_key;

	// Key storage, read one entry a cycle during the scan.
	pdf_ram #(
		.WIDTH (pdf_pkg::KEY_W),
		.DEPTH (ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (store_key),
		.waddr (wslot_q),
		.wdata (key_q),
		.re    (cmd.scan_step),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	// Compare of the entry read in the previous cycle.
	assign entry_ok  = rd_vld_s1 && valid_q[idx_s1];
	assign key_match = entry_ok && (rd_data == key_q);
	assign src_match = entry_ok &&
		(rd_data[pdf_pkg::SRC_LSB +: pdf_pkg::FIELD_W] ==
		 key_q[pdf_pkg::SRC_LSB +: pdf_pkg::FIELD_W]);

	// A new key is stored when an accept found no match.
	assign store_key = cmd.commit && (op_q == pdf_pkg::OP_ACCEPT) && !hit_q;

	// Item register; the key needs no reset.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			key_q <= {packet_type, source_id, sequence_req};
		end
		if (cmd.scan_step) begin
			idx_s1 <= idx_q;
		end
	end

	// Operation, scan counter and hit flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q      <= pdf_pkg::OP_ACCEPT;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_step;
			if (cmd.load_item) begin
				op_q  <= pdf_pkg::pdf_op_t'(operation);
				idx_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (cmd.scan_step) begin
					idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
				end
				if (key_match) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// Valid bits and round-robin write pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			wslot_q <= '0;
		end else begin
			priority if (cmd.commit && (op_q == pdf_pkg::OP_CLEAR)) begin
				valid_q <= '0;
				wslot_q <= '0;
			end else if (store_key) begin
				valid_q[wslot_q] <= 1'b1;
				wslot_q          <= (wslot_q == LAST_IDX) ? '0 : wslot_q + 1'b1;
			end else if (src_match && (op_q == pdf_pkg::OP_PURGE)) begin
				valid_q[idx_s1] <= 1'b0;
			end
		end
	end

	// Result register: holds one result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			present_q  <= hit_q &&
				((op_q == pdf_pkg::OP_ACCEPT) || (op_q == pdf_pkg::OP_LOOKUP));
			accepted_q <= !hit_q && (op_q == pdf_pkg::OP_ACCEPT);
		end
	end

	assign out_valid = out_valid_q;
	assign present   = present_q;
	assign accepted  = accepted_q;

	// Status to the controller. The operation comes straight from the input while an item is taken in.
	always_comb begin
		sts           = '0;
		sts.op        = cmd.load_item ? pdf_pkg::pdf_op_t'(operation) : op_q;
		sts.scan_last = (idx_q == LAST_IDX);
		sts.out_free  = !out_valid_q || out_ready;
	end

endmodule

// ----- rtl/packet_duplicate_filter.sv -----
// Packet duplicate filter. Each item (accept, lookup, purge or clear) goes from its transfer
// in through a scan of the key RAM, a drain, a commit and a result load, except a clear,
// which skips the scan and the drain; the scan reads one entry per cycle on the single
// read port. One item is worked at a time; a finished result waits in an output register
// while the next item is taken in. Valid bits are flip-flops cleared by reset, so no
// clearing pass runs after reset.
module packet_duplicate_filter #(
	parameter int ENTRIES = pdf_pkg::DEF_ENTRIES
) (
	input logic         clk,
	input logic         arst_n,
	pdf_in_if.sink      req,
	pdf_out_if.source   rsp
);

	pdf_pkg::pdf_cmd_t cmd;
	pdf_pkg::pdf_sts_t sts;

	// Controller.
	pdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath.
	pdf_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (req.operation),
		.packet_type  (req.packet_type),
		.source_id    (req.source_id),
		.sequence_req (req.sequence_req),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.present      (rsp.present),
		.accepted     (rsp.accepted)
	);

endmodule

// ----- rtl/pdf_checker.sv -----
// Port-level assertions of the packet duplicate filter and their bind to the top level.
// Depends on packet_duplicate_filter and its channel interfaces.
module pdf_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_present,
	input logic rsp_accepted
);

	// A stalled result stays put.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_present) &&
		$stable(rsp_accepted))
		else $error("stalled result changed");

	// A result never reports a key as both present and accepted.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_present && rsp_accepted))
		else $error("result both present and accepted");

	// The filter works on one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second item taken while busy");

	// A new result never appears right after an input transfer.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result appeared too early");

endmodule

bind packet_duplicate_filter pdf_checker u_pdf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_present  (rsp.present),
	.rsp_accepted (rsp.accepted)
);

// ----- tb/packet_duplicate_filter_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the packet duplicate filter: directed and random transfers.
// Depends on pdf_pkg, the pdf_in_if / pdf_out_if channel interfaces and the filter itself.

localparam int TB_ENTRIES = pdf_pkg::DEF_ENTRIES;

typedef struct {
	bit present;
	bit accepted;
} dup_verdict_t;

// Tracks the key table of the filter and the verdicts still owed by it.
class dup_filter_scoreboard;
	logic [pdf_pkg::KEY_W-1:0] seen_keys [TB_ENTRIES];
	bit                        key_live  [TB_ENTRIES];
	int unsigned               next_slot;
	dup_verdict_t              owed_verdicts [$];
	int unsigned               errors;

	function new();
		foreach (key_live[i]) begin
			key_live[i]  = 1'b0;
			seen_keys[i] = '0;
		end
		next_slot = 0;
		errors    = 0;
	endfunction

	// Applies one input transfer to the table copy and queues its verdict.
	function void record_request(pdf_pkg::pdf_op_t op, logic [7:0] ptype,
		logic [7:0] src, logic [7:0] seq);
		logic [pdf_pkg::KEY_W-1:0] key;
		bit                        hit;
		dup_verdict_t              verdict;
		key = {ptype, src, seq};
		hit = 1'b0;
		verdict.present  = 1'b0;
		verdict.accepted = 1'b0;
		foreach (key_live[i]) begin
			if (key_live[i] && seen_keys[i] == key) begin
				hit = 1'b1;
			end
		end
		case (op)
			pdf_pkg::OP_ACCEPT: begin
				if (hit) begin
					verdict.present = 1'b1;
				end else begin
					// Oldest-first replacement: the slot under the pointer is taken
					// whether or not it still holds a live key.
					seen_keys[next_slot] = key;
					key_live[next_slot]  = 1'b1;
					next_slot            = (next_slot + 1) % TB_ENTRIES;
					verdict.accepted     = 1'b1;
				end
			end
			pdf_pkg::OP_LOOKUP: begin
				verdict.present = hit;
			end
			pdf_pkg::OP_PURGE: begin
				foreach (key_live[i]) begin
					if (seen_keys[i][pdf_pkg::SRC_LSB +: pdf_pkg::FIELD_W] == src) begin
						key_live[i] = 1'b0;
					end
				end
			end
			default: begin
				foreach (key_live[i]) begin
					key_live[i] = 1'b0;
				end
				next_slot = 0;
			end
		endcase
		owed_verdicts.push_back(verdict);
	endfunction

	// Compares one output transfer with the oldest owed verdict.
	function void check_verdict(logic present, logic accepted);
		dup_verdict_t want;
		if (owed_verdicts.size() == 0) begin
			$error("unexpected result: present=%0b accepted=%0b", present, accepted);
			errors++;
			return;
		end
		want = owed_verdicts.pop_front();
		if (present !== want.present) begin
			$error("present: expected %0b, actual %0b", want.present, present);
			errors++;
		end
		if (accepted !== want.accepted) begin
			$error("accepted: expected %0b, actual %0b", want.accepted, accepted);
			errors++;
		end
	endfunction

	function int unsigned owed();
		return owed_verdicts.size();
	endfunction
endclass

module packet_duplicate_filter_tb;
	localparam int RANDOM_ITEMS    = 1000;
	localparam int QUIET_TAIL      = 150;
	localparam int HOLD_OFF_CYCLES = 250;
	localparam int DRAIN_CYCLES    = TB_ENTRIES + 3 + 8;
	localparam int CYCLE_LIMIT     = 400000;

	logic clk = 1'b0;
	logic arst_n;

	pdf_in_if  req_if ();
	pdf_out_if rsp_if ();

	dup_filter_scoreboard sb = new();

	bit tx_idles_on;
	bit rx_stalls_on;
	bit tail_quiet;
	bit hold_off_req;
	int unsigned cycle_count = 0;
	logic [pdf_pkg::KEY_W-1:0] recent_keys [$];

	packet_duplicate_filter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Clock: 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offers one item and waits for its transfer, then maybe idles for a burst.
	task automatic send_item(pdf_pkg::pdf_op_t op, logic [7:0] ptype, logic [7:0] src,
		logic [7:0] seq);
		req_if.valid        <= 1'b1;
		req_if.operation    <= op;
		req_if.packet_type  <= ptype;
		req_if.source_id    <= src;
		req_if.sequence_req <= seq;
		do begin
			@(posedge clk);
		end while (!req_if.ready);
		sb.record_request(op, ptype, src, seq);
		if (tx_idles_on && !tail_quiet && $urandom_range(0, 3) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// Random item: keys come mostly from a narrow pool or from recent accepts so
	// that hits, purges of live sources and table wrap-around all happen often.
	task automatic send_random();
		int unsigned               pick;
		logic [pdf_pkg::KEY_W-1:0] key;
		pdf_pkg::pdf_op_t          op;
		pick = $urandom_range(0, 99);
		if (pick < 52) begin
			op = pdf_pkg::OP_ACCEPT;
		end else if (pick < 82) begin
			op = pdf_pkg::OP_LOOKUP;
		end else if (pick < 98) begin
			op = pdf_pkg::OP_PURGE;
		end else begin
			op = pdf_pkg::OP_CLEAR;
		end
		if (recent_keys.size() > 0 && $urandom_range(0, 2) == 0) begin
			key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
		end else if ($urandom_range(0, 9) == 0) begin
			key = pdf_pkg::KEY_W'($urandom());
		end else begin
			key[23:16] = 8'($urandom_range(0, 2));
			key[15:8]  = 8'($urandom_range(0, 5));
			key[7:0]   = 8'($urandom_range(0, 7));
		end
		if (op == pdf_pkg::OP_ACCEPT) begin
			recent_keys.push_back(key);
			if (recent_keys.size() > 20) begin
				void'(recent_keys.pop_front());
			end
		end
		send_item(op, key[23:16], key[15:8], key[7:0]);
	endtask

	// Receiver: checks each output transfer and stalls in bursts.
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready) begin
				sb.check_verdict(rsp_if.present, rsp_if.accepted);
			end
			if (hold_off_req) begin
				// Long hold-off so the result register fills and the input backs up.
				hold_off_req = 1'b0;
				hold_left    = HOLD_OFF_CYCLES;
			end else if (hold_left > 0) begin
				hold_left--;
			end else if (rx_stalls_on && !tail_quiet && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(1, 15);
			end
			rsp_if.ready <= (hold_left == 0);
		end
	end

	// Main sequence: reset, directed items, random items, drain.
	initial begin
		int n;
		arst_n              <= 1'b0;
		req_if.valid        <= 1'b0;
		req_if.operation    <= pdf_pkg::OP_ACCEPT;
		req_if.packet_type  <= '0;
		req_if.source_id    <= '0;
		req_if.sequence_req <= '0;
		tx_idles_on  = 1'b1;
		rx_stalls_on = 1'b1;
		tail_quiet   = 1'b0;
		hold_off_req = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes, a duplicate, lookups that hit and miss.
		send_item(pdf_pkg::OP_ACCEPT, 8'h00, 8'h00, 8'h00);
		send_item(pdf_pkg::OP_ACCEPT, 8'hFF, 8'hFF, 8'hFF);
		send_item(pdf_pkg::OP_ACCEPT, 8'h00, 8'h00, 8'h00);
		send_item(pdf_pkg::OP_LOOKUP, 8'hFF, 8'hFF, 8'hFF);
		// Purge ignores type and sequence; only the source selects entries.
		send_item(pdf_pkg::OP_PURGE, 8'hAA, 8'hFF, 8'h55);
		send_item(pdf_pkg::OP_LOOKUP, 8'hFF, 8'hFF, 8'hFF);
		// Clear empties the table and rewinds the write pointer.
		send_item(pdf_pkg::OP_CLEAR, 8'hFF, 8'hFF, 8'hFF);
		send_item(pdf_pkg::OP_LOOKUP, 8'h00, 8'h00, 8'h00);
		// Fill the table and wrap once, so the oldest key is overwritten.
		for (int i = 0; i <= TB_ENTRIES; i++) begin
			send_item(pdf_pkg::OP_ACCEPT, 8'h01, 8'h02, 8'(i));
		end
		send_item(pdf_pkg::OP_LOOKUP, 8'h01, 8'h02, 8'h00);
		send_item(pdf_pkg::OP_LOOKUP, 8'h01, 8'h02, 8'h01);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				tx_idles_on  = ($urandom_range(0, 2) != 0);
				rx_stalls_on = ($urandom_range(0, 2) != 0);
			end
			if (n == RANDOM_ITEMS - QUIET_TAIL) begin
				tail_quiet = 1'b1;
			end
			if (n == 300) begin
				hold_off_req = 1'b1;
			end
			send_random();
		end
		req_if.valid <= 1'b0;

		while (sb.owed() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
